/* design/bvmc_pkg.sv */
// Shared types, constants and the control program of the balance/velocity controller.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`default_nettype none

package bvmc_pkg;

	// Field and datapath widths.
	localparam int STEP_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GAIN_W     = 24;
	localparam int ANG_W      = 16;
	localparam int CNT_W      = 12;
	localparam int SUM_W      = 13;
	localparam int STATE_W    = 24;
	localparam int PROD_W     = 48;
	localparam int ACC_W      = 49;
	localparam int BAL_W      = 26;
	localparam int TRUNC_W    = 33;
	localparam int DRIVE_SUM_W = 27;
	localparam int DRIVE_W    = 9;
	localparam int LIMIT_W    = 8;
	localparam int PERIOD_W   = 4;

	// Filter coefficients: 179/256 keeps the old value, 77/256 takes the new sum.
	// The new-sum coefficient is prescaled by 256 so the sum enters in Q.8.
	localparam logic signed [GAIN_W-1:0] FILT_KEEP_C = 24'sd179;
	localparam logic signed [GAIN_W-1:0] FILT_NEW_C  = 24'sd19712;

	// Integral fold-back and clamp, in Q.8.
	localparam logic signed [STATE_W-1:0] FOLD_BOUND_C = 24'sd76800;
	localparam logic signed [STATE_W-1:0] FOLD_STEP_C  = 24'sd51200;
	localparam logic signed [STATE_W:0]   INTEG_MAX_C  = 25'sd5376000;

	// Saturation bounds of the velocity term.
	localparam logic signed [TRUNC_W-1:0] TERM_MAX_C = 33'sd8388607;
	localparam logic signed [TRUNC_W-1:0] TERM_MIN_C = -33'sd8388608;

	// Named steps that the program jumps to.
	localparam logic [STEP_W-1:0] STEP_DRIVE = 4'd10;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PD_GAIN_P       = 3'd0,
		REG_PD_GAIN_D       = 3'd1,
		REG_PI_GAIN_P       = 3'd2,
		REG_PI_GAIN_I       = 3'd3,
		REG_ANGLE_OFFSET    = 3'd4,
		REG_CLEAR_ANGLE     = 3'd5,
		REG_DRIVE_LIMIT     = 3'd6,
		REG_VELOCITY_PERIOD = 3'd7
	} cfg_idx_t;

	// Operand pair presented to the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_KP_BIAS,
		MUL_KD_RATE,
		MUL_FNEW_SUM,
		MUL_FKEEP_FS,
		MUL_VKP_FS,
		MUL_VKI_INT
	} mul_sel_t;

	// Accumulator action on the registered product.
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	// Register written from the accumulator or state this step.
	typedef enum logic [2:0] {
		WR_NONE,
		WR_BAL,
		WR_FILT,
		WR_INTEG,
		WR_VEL,
		WR_DRIVE
	} wr_sel_t;

	// Sequencing of the step counter.
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_NOVEL,
		JMP_END
	} jmp_t;

	// One control word of the program.
	typedef struct packed {
		mul_sel_t           mul;
		acc_op_t            acc;
		wr_sel_t            wr;
		jmp_t               jmp;
		logic [STEP_W-1:0]  target;
	} ucode_t;

	// Control word as issued to the datapath, with its execute enable.
	typedef struct packed {
		logic   en;
		ucode_t uc;
	} ctrl_t;

	// Configuration register bundle.
	typedef struct packed {
		logic signed [GAIN_W-1:0] pd_gain_p;
		logic signed [GAIN_W-1:0] pd_gain_d;
		logic signed [GAIN_W-1:0] pi_gain_p;
		logic signed [GAIN_W-1:0] pi_gain_i;
		logic signed [ANG_W-1:0]  angle_offset;
		logic signed [ANG_W-1:0]  clear_angle;
		logic [LIMIT_W-1:0]       drive_limit;
		logic [PERIOD_W-1:0]      velocity_period;
	} cfg_t;

	// Control program. The multiplier result is registered, so the accumulator
	// consumes in each step the product set up by the step before it.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		uc = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, jmp: JMP_END, target: '0};
		case (step)
			4'd0: uc = '{mul: MUL_KP_BIAS, acc: ACC_HOLD, wr: WR_NONE,
				jmp: JMP_NEXT, target: '0};
			4'd1: uc = '{mul: MUL_KD_RATE, acc: ACC_LOAD, wr: WR_NONE,
				jmp: JMP_NEXT, target: '0};
			4'd2: uc = '{mul: MUL_FNEW_SUM, acc: ACC_ADD, wr: WR_NONE,
				jmp: JMP_NEXT, target: '0};
			4'd3: uc = '{mul: MUL_FKEEP_FS, acc: ACC_LOAD, wr: WR_BAL,
				jmp: JMP_NOVEL, target: STEP_DRIVE};
			4'd4: uc = '{mul: MUL_NONE, acc: ACC_ADD, wr: WR_NONE,
				jmp: JMP_NEXT, target: '0};
			4'd5: uc = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_FILT,
				jmp: JMP_NEXT, target: '0};
			4'd6: uc = '{mul: MUL_VKP_FS, acc: ACC_HOLD, wr: WR_INTEG,
				jmp: JMP_NEXT, target: '0};
			4'd7: uc = '{mul: MUL_VKI_INT, acc: ACC_LOAD, wr: WR_NONE,
				jmp: JMP_NEXT, target: '0};
			4'd8: uc = '{mul: MUL_NONE, acc: ACC_ADD, wr: WR_NONE,
				jmp: JMP_NEXT, target: '0};
			4'd9: uc = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_VEL,
				jmp: JMP_NEXT, target: '0};
			STEP_DRIVE: uc = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_DRIVE,
				jmp: JMP_END, target: '0};
			default: uc = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE,
				jmp: JMP_END, target: '0};
		endcase
		return uc;
	endfunction

endpackage

`default_nettype wire

/* design/bvmc_seq.sv */
// Program sequencer: step counter, control store lookup and conditional jump.
// Depends on bvmc_pkg for the control word types and the program.
`default_nettype none

module bvmc_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_accept,
	input  wire logic           run_vel,
	input  wire logic           out_hold,
	output logic                busy,
	output bvmc_pkg::ctrl_t     ctrl
);
	import bvmc_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	ucode_t            uc;
	logic              stall;

	// Fetch the control word; the drive step waits while the result register holds a word that is not being taken.
	always_comb begin
		uc      = ucode_rom(step_q);
		stall   = (uc.wr == WR_DRIVE) && out_hold;
		ctrl.en = busy_q && !stall;
		ctrl.uc = uc;
	end

	assign busy = busy_q;

	// Step counter with a jump past the velocity loop on ticks where it does not run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (ctrl.en) begin
			case (uc.jmp)
				JMP_END: begin
					busy_q <= 1'b0;
				end
				JMP_NOVEL: begin
					step_q <= run_vel ? step_q + 1'b1 : uc.target;
				end
				default: begin
					step_q <= step_q + 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/bvmc_dp.sv */
// Datapath: input holding registers, tick counter, shared multiplier, accumulator,
// loop state and the result register. Depends on bvmc_pkg.
`default_nettype none

module bvmc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_accept,
	input  wire logic [bvmc_pkg::ANG_W-1:0]    tilt_angle,
	input  wire logic [bvmc_pkg::ANG_W-1:0]    tilt_rate,
	input  wire logic [bvmc_pkg::CNT_W-1:0]    left_count,
	input  wire logic [bvmc_pkg::CNT_W-1:0]    right_count,
	input  wire bvmc_pkg::cfg_t                cfg,
	input  wire bvmc_pkg::ctrl_t               ctrl,
	input  wire logic                          out_ready,
	output logic                               run_vel,
	output logic                               out_valid,
	output logic [bvmc_pkg::DRIVE_W-1:0]       motor_drive,
	output logic                               velocity_updated
);
	import bvmc_pkg::*;

	// Item registers.
	logic signed [ANG_W-1:0]  angle_q;
	logic signed [ANG_W-1:0]  rate_q;
	logic signed [SUM_W-1:0]  sum_q;

	// Control and loop state.
	logic [PERIOD_W-1:0]       tick_q;
	logic                      run_q;
	logic signed [STATE_W-1:0] fs_q;
	logic signed [STATE_W-1:0] integ_q;
	logic signed [STATE_W-1:0] vt_q;
	logic signed [BAL_W-1:0]   bal_q;

	// Arithmetic registers.
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	// Result register.
	logic                      valid_q;
	logic [DRIVE_W-1:0]        drive_q;
	logic                      upd_q;

	logic [PERIOD_W-1:0]       tick_nxt;
	logic                      run_nxt;
	logic signed [SUM_W-1:0]   sum_in;
	logic signed [ANG_W:0]     bias;
	logic signed [GAIN_W-1:0]  mul_a;
	logic signed [GAIN_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [TRUNC_W-1:0] acc_trunc;
	logic signed [STATE_W-1:0] vel_sat;
	logic signed [STATE_W-1:0] integ_fold;
	logic signed [STATE_W:0]   integ_sum;
	logic signed [STATE_W-1:0] integ_clamp;
	logic signed [DRIVE_SUM_W-1:0] drive_sum;
	logic signed [DRIVE_SUM_W-1:0] drive_lim;
	logic signed [DRIVE_SUM_W-1:0] drive_clamp;

	// Tick counter advance; a period of zero or one runs the velocity loop every tick.
	always_comb begin
		tick_nxt = tick_q + 1'b1;
		run_nxt  = (tick_nxt >= cfg.velocity_period);
		sum_in   = $signed({left_count[CNT_W-1], left_count})
			+ $signed({right_count[CNT_W-1], right_count});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			run_q  <= 1'b0;
		end else if (in_accept) begin
			tick_q <= run_nxt ? '0 : tick_nxt;
			run_q  <= run_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			angle_q <= $signed(tilt_angle);
			rate_q  <= $signed(tilt_rate);
			sum_q   <= sum_in;
		end
	end

	assign run_vel = run_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		bias = $signed({angle_q[ANG_W-1], angle_q})
			- $signed({cfg.angle_offset[ANG_W-1], cfg.angle_offset});
		case (ctrl.uc.mul)
			MUL_KP_BIAS: begin
				mul_a = cfg.pd_gain_p;
				mul_b = $signed({{(GAIN_W-ANG_W-1){bias[ANG_W]}}, bias});
			end
			MUL_KD_RATE: begin
				mul_a = cfg.pd_gain_d;
				mul_b = $signed({{(GAIN_W-ANG_W){rate_q[ANG_W-1]}}, rate_q});
			end
			MUL_FNEW_SUM: begin
				mul_a = FILT_NEW_C;
				mul_b = $signed({{(GAIN_W-SUM_W){sum_q[SUM_W-1]}}, sum_q});
			end
			MUL_FKEEP_FS: begin
				mul_a = FILT_KEEP_C;
				mul_b = fs_q;
			end
			MUL_VKP_FS: begin
				mul_a = cfg.pi_gain_p;
				mul_b = fs_q;
			end
			MUL_VKI_INT: begin
				mul_a = cfg.pi_gain_i;
				mul_b = integ_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	// Result shaping from the accumulator and the loop state.
	always_comb begin
		prod_ext  = $signed({prod_q[PROD_W-1], prod_q});
		// Division by 65536 that truncates toward zero.
		acc_rnd   = acc_q + (acc_q[ACC_W-1] ? 49'sd65535 : 49'sd0);
		acc_trunc = acc_rnd[ACC_W-1:16];

		if (acc_trunc > TERM_MAX_C) begin
			vel_sat = 24'sh7FFFFF;
		end else if (acc_trunc < TERM_MIN_C) begin
			vel_sat = -24'sh800000;
		end else begin
			vel_sat = acc_trunc[STATE_W-1:0];
		end

		// Fold-back of the old integral before the new speed is added.
		if (integ_q > FOLD_BOUND_C) begin
			integ_fold = integ_q - FOLD_STEP_C;
		end else if (integ_q < -FOLD_BOUND_C) begin
			integ_fold = integ_q + FOLD_STEP_C;
		end else begin
			integ_fold = integ_q;
		end

		integ_sum = $signed({integ_q[STATE_W-1], integ_q}) + $signed({fs_q[STATE_W-1], fs_q});
		if (integ_sum > INTEG_MAX_C) begin
			integ_clamp = INTEG_MAX_C[STATE_W-1:0];
		end else if (integ_sum < -INTEG_MAX_C) begin
			integ_clamp = 24'(-INTEG_MAX_C);
		end else begin
			integ_clamp = integ_sum[STATE_W-1:0];
		end

		// Drive: balance plus held velocity term, clamped symmetrically.
		drive_sum = $signed({bal_q[BAL_W-1], bal_q})
			+ $signed({{(DRIVE_SUM_W-STATE_W){vt_q[STATE_W-1]}}, vt_q});
		drive_lim = $signed({{(DRIVE_SUM_W-LIMIT_W){1'b0}}, cfg.drive_limit});
		if (drive_sum > drive_lim) begin
			drive_clamp = drive_lim;
		end else if (drive_sum < -drive_lim) begin
			drive_clamp = -drive_lim;
		end else begin
			drive_clamp = drive_sum;
		end
	end

	// Product register and accumulator.
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= prod;
			case (ctrl.uc.acc)
				ACC_LOAD: acc_q <= prod_ext;
				ACC_ADD:  acc_q <= acc_q + prod_ext;
				default:  acc_q <= acc_q;
			endcase
			if (ctrl.uc.wr == WR_BAL) begin
				bal_q <= acc_trunc[BAL_W-1:0];
			end
		end
	end

	// Loop state written by the program.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= '0;
			integ_q <= '0;
			vt_q    <= '0;
		end else if (ctrl.en) begin
			case (ctrl.uc.wr)
				WR_FILT: begin
					fs_q    <= acc_q[8 +: STATE_W];
					integ_q <= integ_fold;
				end
				WR_INTEG: begin
					integ_q <= integ_clamp;
				end
				WR_VEL: begin
					vt_q <= vel_sat;
					// The integral restarts while the robot is not standing.
					if (angle_q < cfg.clear_angle) begin
						integ_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register: filled by the drive step, emptied by the downstream handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.en && (ctrl.uc.wr == WR_DRIVE)) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en && (ctrl.uc.wr == WR_DRIVE)) begin
			drive_q <= drive_clamp[DRIVE_W-1:0];
			upd_q   <= run_q;
		end
	end

	assign out_valid        = valid_q;
	assign motor_drive      = drive_q;
	assign velocity_updated = upd_q;

endmodule

`default_nettype wire

/* design/balance_velocity_motor_controller.sv */
// The control program steps all products through one shared 24x24 multiplier: the balance
// steps, then on ticks where the velocity loop runs its steps, then the drive step.
// A new input word is taken only once the current tick is through; the input reopens
// the cycle after the drive step, which waits while the previous result word is still
// unaccepted.
// Reset: configuration returns to its defaults; tick counter, filtered speed, integral and velocity term clear.
// Top level of the controller; depends on bvmc_pkg, bvmc_seq and bvmc_dp.
`default_nettype none

module balance_velocity_motor_controller (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// s_tdata: tilt_angle[15:0], tilt_rate[31:16], left_count[43:32], right_count[55:44]
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [55:0]                        s_tdata,
	// m_tdata: motor_drive[8:0], zero fill [15:9]
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [15:0]                             m_tdata,
	// m_tuser: velocity_updated[0]
	output logic                                    m_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [bvmc_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire logic [bvmc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bvmc_pkg::*;

	cfg_t               cfg_q;
	ctrl_t              ctrl;
	logic               busy;
	logic               in_accept;
	logic               run_vel;
	logic [DRIVE_W-1:0] motor_drive;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pd_gain_p       <= '0;
			cfg_q.pd_gain_d       <= '0;
			cfg_q.pi_gain_p       <= '0;
			cfg_q.pi_gain_i       <= '0;
			cfg_q.angle_offset    <= 16'sd512;
			cfg_q.clear_angle     <= 16'sd1280;
			cfg_q.drive_limit     <= 8'd250;
			cfg_q.velocity_period <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				REG_PD_GAIN_P:       cfg_q.pd_gain_p       <= $signed(cfg_wdata);
				REG_PD_GAIN_D:       cfg_q.pd_gain_d       <= $signed(cfg_wdata);
				REG_PI_GAIN_P:       cfg_q.pi_gain_p       <= $signed(cfg_wdata);
				REG_PI_GAIN_I:       cfg_q.pi_gain_i       <= $signed(cfg_wdata);
				REG_ANGLE_OFFSET:    cfg_q.angle_offset    <= $signed(cfg_wdata[ANG_W-1:0]);
				REG_CLEAR_ANGLE:     cfg_q.clear_angle     <= $signed(cfg_wdata[ANG_W-1:0]);
				REG_DRIVE_LIMIT:     cfg_q.drive_limit     <= cfg_wdata[LIMIT_W-1:0];
				REG_VELOCITY_PERIOD: cfg_q.velocity_period <= cfg_wdata[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// One tick in flight at a time; the result register decouples the output side.
	assign s_tready  = !busy;
	assign in_accept = s_tvalid && s_tready;

	bvmc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.run_vel   (run_vel),
		.out_hold  (m_tvalid && !m_tready),
		.busy      (busy),
		.ctrl      (ctrl)
	);

	bvmc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_accept        (in_accept),
		.tilt_angle       (s_tdata[15:0]),
		.tilt_rate        (s_tdata[31:16]),
		.left_count       (s_tdata[43:32]),
		.right_count      (s_tdata[55:44]),
		.cfg              (cfg_q),
		.ctrl             (ctrl),
		.out_ready        (m_tready),
		.run_vel          (run_vel),
		.out_valid        (m_tvalid),
		.motor_drive      (motor_drive),
		.velocity_updated (m_tuser)
	);

	assign m_tdata = {7'b0, motor_drive};

endmodule

`default_nettype wire

/* design/bvmc_chk.sv */
// Port-level checks of the controller, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module bvmc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// A tick occupies the block, so the input side closes right after a word is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted a word while a tick was in progress");

	// A result never appears in the cycle right after the word that causes it.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared too soon after an input word");

	// The clamped drive never reaches the most negative 9-bit code and the fill is zero.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] != 9'h100) && (m_tdata[15:9] == 7'b0))
		else $error("motor drive outside its clamp range");

	// A stalled result holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed or dropped");

endmodule

bind balance_velocity_motor_controller bvmc_chk u_bvmc_chk (.*);

`default_nettype wire
